>>> src/rbsu_pkg.sv
// Shared types and constants for the raw byte sample unpacker.
// Used by rbsu_core and raw_byte_sample_unpacker_top; depends on nothing.
`timescale 1ns / 1ps

package rbsu_pkg;

    localparam int CNT_W        = 20;
    localparam int CH_W         = 8;
    localparam int CH_CFG_W     = 9;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 20;
    localparam int MAX_CHANNELS = 256;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_BYTES       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BINARY      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MSB_FIRST          = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD_SKIP          = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LEN          = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_LEN            = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS           = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLES_PER_RECORD = 3'd7;

    localparam logic [15:0] SIGN16 = 16'h8000;

    typedef struct packed {
        logic [1:0]          sample_bytes;
        logic                offset_binary;
        logic                msb_first;
        logic [CNT_W-1:0]    block_len;
        logic [CNT_W-1:0]    gap_len;
        logic [CH_CFG_W-1:0] channels;
        logic [CNT_W-1:0]    samples_per_record;
    } t_cfg;

    typedef struct packed {
        logic signed [15:0] sample_value;
        logic [CH_W-1:0]    channel_index;
        logic [CNT_W-1:0]   frame_index;
        logic               record_end;
    } t_result;

endpackage

>>> src/rbsu_core.sv
// Per-byte stream state of the unpacker: lead skip, gap skip, byte pairing,
// sample decode and channel/frame counters. Depends on rbsu_pkg.
`timescale 1ns / 1ps

module rbsu_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rbsu_pkg::t_cfg                i_cfg,
    input  logic                          i_lead_load,
    input  logic [rbsu_pkg::CNT_W-1:0]    i_lead_value,
    input  logic                          i_fire,
    input  logic [7:0]                    i_byte,
    output logic                          o_has_result,
    output rbsu_pkg::t_result             o_result
);

    logic [rbsu_pkg::CNT_W-1:0] r_lead_left, n_lead_left;
    logic [rbsu_pkg::CNT_W-1:0] r_block_count, n_block_count;
    logic [rbsu_pkg::CNT_W-1:0] r_gap_left, n_gap_left;
    logic                       r_byte_phase, n_byte_phase;
    logic [7:0]                 r_held_byte, n_held_byte;
    logic [rbsu_pkg::CH_W-1:0]  r_channel_count, n_channel_count;
    logic [rbsu_pkg::CNT_W-1:0] r_frame_count, n_frame_count;

    always_comb begin
        logic                          data_ok;
        logic [15:0]                   raw;
        logic [15:0]                   value;
        logic [rbsu_pkg::CH_CFG_W-1:0] nch;
        logic [rbsu_pkg::CNT_W-1:0]    nfr;
        logic                          last_ch;
        logic                          last_fr;
        logic                          one_byte;

        n_lead_left     = r_lead_left;
        n_block_count   = r_block_count;
        n_gap_left      = r_gap_left;
        n_byte_phase    = r_byte_phase;
        n_held_byte     = r_held_byte;
        n_channel_count = r_channel_count;
        n_frame_count   = r_frame_count;
        o_has_result    = 1'b0;
        data_ok         = 1'b0;
        raw             = 16'h0000;
        one_byte        = (i_cfg.sample_bytes == 2'd1);

        // Skip stages: lead bytes, then gap bytes, then the block boundary.
        priority if (r_lead_left != '0) begin
            n_lead_left = r_lead_left - 1'b1;
        end else if (r_gap_left != '0) begin
            n_gap_left = r_gap_left - 1'b1;
        end else if (i_cfg.block_len != '0 && r_block_count >= i_cfg.block_len) begin
            if (i_cfg.gap_len != '0) begin
                n_block_count = '0;
                n_gap_left    = i_cfg.gap_len - 1'b1;
            end else begin
                // A zero-length gap restarts the count with this byte.
                n_block_count = rbsu_pkg::CNT_W'(1);
                data_ok       = 1'b1;
            end
        end else begin
            if (i_cfg.block_len != '0) begin
                n_block_count = r_block_count + 1'b1;
            end
            data_ok = 1'b1;
        end

        // Byte pairing.
        if (data_ok) begin
            if (one_byte) begin
                n_byte_phase = 1'b0;
                raw          = {i_byte, 8'h00};
                o_has_result = 1'b1;
            end else if (!r_byte_phase) begin
                n_held_byte  = i_byte;
                n_byte_phase = 1'b1;
            end else begin
                n_byte_phase = 1'b0;
                raw          = i_cfg.msb_first ? {r_held_byte, i_byte}
                                               : {i_byte, r_held_byte};
                o_has_result = 1'b1;
            end
        end

        if (i_cfg.offset_binary) begin
            raw = raw ^ rbsu_pkg::SIGN16;
        end
        value = one_byte ? {{8{raw[15]}}, raw[15:8]} : raw;

        // Clamp the channel and record limits to their legal ranges.
        priority if (i_cfg.channels == '0) begin
            nch = rbsu_pkg::CH_CFG_W'(1);
        end else if (i_cfg.channels > rbsu_pkg::CH_CFG_W'(rbsu_pkg::MAX_CHANNELS)) begin
            nch = rbsu_pkg::CH_CFG_W'(rbsu_pkg::MAX_CHANNELS);
        end else begin
            nch = i_cfg.channels;
        end
        nfr = (i_cfg.samples_per_record == '0) ? rbsu_pkg::CNT_W'(1)
                                               : i_cfg.samples_per_record;

        last_ch = ({1'b0, r_channel_count} + 1'b1) >= nch;
        last_fr = ({1'b0, r_frame_count} + 1'b1) >= {1'b0, nfr};

        o_result.sample_value  = value;
        o_result.channel_index = r_channel_count;
        o_result.frame_index   = r_frame_count;
        o_result.record_end    = last_ch & last_fr;

        if (o_has_result) begin
            if (last_ch) begin
                n_channel_count = '0;
                n_frame_count   = last_fr ? '0 : r_frame_count + 1'b1;
            end else begin
                n_channel_count = r_channel_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_left     <= '0;
            r_block_count   <= '0;
            r_gap_left      <= '0;
            r_byte_phase    <= 1'b0;
            r_held_byte     <= '0;
            r_channel_count <= '0;
            r_frame_count   <= '0;
        end else begin
            if (i_lead_load) begin
                r_lead_left <= i_lead_value;
            end else if (i_fire) begin
                r_lead_left <= n_lead_left;
            end
            if (i_fire) begin
                r_block_count   <= n_block_count;
                r_gap_left      <= n_gap_left;
                r_byte_phase    <= n_byte_phase;
                r_held_byte     <= n_held_byte;
                r_channel_count <= n_channel_count;
                r_frame_count   <= n_frame_count;
            end
        end
    end

endmodule

>>> src/raw_byte_sample_unpacker_top.sv
// Top level of the raw byte sample unpacker: configuration registers,
// input register, output register. Depends on rbsu_pkg and rbsu_core.
`timescale 1ns / 1ps

// Usage
// The input channel (i_valid, o_stall, i_data_byte) carries one raw stream
// byte per transfer. The output channel (o_valid, i_stall and the four
// result ports) carries one decoded sample per transfer, tagged with its
// channel index, its frame index within the record and a record end flag.
// Leading bytes, gap bytes and the first byte of a two-byte sample give no
// output transfer.
// A transfer takes place on a rising edge where valid is high and stall low.
// A byte is held in the input register and is then processed into the output
// register. Throughput is one byte per cycle while the receiver does not
// stall, as rbsu_core computes each counter update combinationally.
// When the receiver stalls, the result holds in the output register; one
// more byte may be taken into the input register, after which o_stall rises
// until the result is taken.
// Configuration is written through i_cfg_we, i_cfg_index and i_cfg_data while
// the block is idle. Writing the lead skip register restarts the lead skip.
// Reset is synchronous and active low: registers return to their defaults
// and all counters clear; no result is pending afterwards.

module raw_byte_sample_unpacker_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [rbsu_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [rbsu_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [7:0]                           i_data_byte,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [15:0]                   o_sample_value,
    output logic [rbsu_pkg::CH_W-1:0]            o_channel_index,
    output logic [rbsu_pkg::CNT_W-1:0]           o_frame_index,
    output logic                                 o_record_end
);

    rbsu_pkg::t_cfg    r_cfg;
    rbsu_pkg::t_result core_result;
    rbsu_pkg::t_result r_out;
    logic              r_in_vld;
    logic [7:0]        r_in_byte;
    logic              r_out_vld;
    logic              core_has_result;
    logic              proc_go;
    logic              fire;
    logic              in_accept;
    logic              lead_load;

    // The processing stage may advance whenever the output slot is empty or
    // its result is being taken in this cycle.
    assign proc_go   = !r_out_vld || !i_stall;
    assign fire      = r_in_vld && proc_go;
    assign o_stall   = r_in_vld && !proc_go;
    assign in_accept = i_valid && !o_stall;
    assign lead_load = i_cfg_we && (i_cfg_index == rbsu_pkg::CFG_LEAD_SKIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sample_bytes       <= 2'd2;
            r_cfg.offset_binary      <= 1'b0;
            r_cfg.msb_first          <= 1'b0;
            r_cfg.block_len          <= '0;
            r_cfg.gap_len            <= rbsu_pkg::CNT_W'(1);
            r_cfg.channels           <= rbsu_pkg::CH_CFG_W'(1);
            r_cfg.samples_per_record <= rbsu_pkg::CNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rbsu_pkg::CFG_SAMPLE_BYTES: begin
                    r_cfg.sample_bytes <= i_cfg_data[1:0];
                end
                rbsu_pkg::CFG_OFFSET_BINARY: begin
                    r_cfg.offset_binary <= i_cfg_data[0];
                end
                rbsu_pkg::CFG_MSB_FIRST: begin
                    r_cfg.msb_first <= i_cfg_data[0];
                end
                rbsu_pkg::CFG_LEAD_SKIP: begin
                    // Held in the core's lead counter only.
                end
                rbsu_pkg::CFG_BLOCK_LEN: begin
                    r_cfg.block_len <= i_cfg_data;
                end
                rbsu_pkg::CFG_GAP_LEN: begin
                    r_cfg.gap_len <= i_cfg_data;
                end
                rbsu_pkg::CFG_CHANNELS: begin
                    r_cfg.channels <= i_cfg_data[rbsu_pkg::CH_CFG_W-1:0];
                end
                rbsu_pkg::CFG_SAMPLES_PER_RECORD: begin
                    r_cfg.samples_per_record <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_accept) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_data_byte;
        end
    end

    rbsu_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_lead_load  (lead_load),
        .i_lead_value (i_cfg_data),
        .i_fire       (fire),
        .i_byte       (r_in_byte),
        .o_has_result (core_has_result),
        .o_result     (core_result)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (proc_go) begin
            r_out_vld <= fire && core_has_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && core_has_result) begin
            r_out <= core_result;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_sample_value  = r_out.sample_value;
    assign o_channel_index = r_out.channel_index;
    assign o_frame_index   = r_out.frame_index;
    assign o_record_end    = r_out.record_end;

endmodule
